### hw/rtl/ufbs_pkg.sv
// ----------------------------------------------------------------------------
// ufbs_pkg
// Shared types and constants of the UART boot sequencer.
// ----------------------------------------------------------------------------
package ufbs_pkg;

    localparam logic [7:0] BYTE_STX   = 8'h02;
    localparam logic [7:0] BYTE_SOH   = 8'h01;
    localparam logic [7:0] BYTE_ACK   = 8'h06;
    localparam logic [7:0] CHECK_INIT = 8'h00;

    localparam logic [15:0] IMAGE_LENGTH_RST  = 16'd1;
    localparam logic [15:0] STX_TIMEOUT_RST   = 16'd5000;
    localparam logic [15:0] REPLY_TIMEOUT_RST = 16'd2000;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_RX    = 2'd1;
    localparam logic [1:0] CMD_IMAGE = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic [1:0] REG_IMAGE_LENGTH  = 2'd0;
    localparam logic [1:0] REG_STX_TIMEOUT   = 2'd1;
    localparam logic [1:0] REG_REPLY_TIMEOUT = 2'd2;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_STX   = 3'd1;
    localparam logic [2:0] PH_ACK   = 3'd2;
    localparam logic [2:0] PH_IMAGE = 3'd3;
    localparam logic [2:0] PH_CHECK = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;
    localparam logic [2:0] PH_FAIL  = 3'd6;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_STX_TIMEOUT = 3'd1;
    localparam logic [2:0] ERR_ACK_TIMEOUT = 3'd2;
    localparam logic [2:0] ERR_CHK_TIMEOUT = 3'd3;
    localparam logic [2:0] ERR_UNEXPECTED  = 3'd4;
    localparam logic [2:0] ERR_MISMATCH    = 3'd5;
    localparam logic [2:0] ERR_OUT_OF_PH   = 3'd6;

    localparam int JOB_DEPTH = 4;
    localparam int JOB_AW    = $clog2(JOB_DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_STX   = 7'b0000010,
        ST_ACK   = 7'b0000100,
        ST_IMAGE = 7'b0001000,
        ST_CHECK = 7'b0010000,
        ST_DONE  = 7'b0100000,
        ST_FAIL  = 7'b1000000
    } state_t;

    // One job per accepted item; a header job expands to SOH, len low, len high.
    typedef struct packed {
        logic       header;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] len_hi;
        logic [2:0] phase;
        logic [2:0] error;
    } job_t;

    function automatic logic [2:0] phase_code(input state_t st);
        logic [2:0] code;
        case (st)
            ST_STX:   code = PH_STX;
            ST_ACK:   code = PH_ACK;
            ST_IMAGE: code = PH_IMAGE;
            ST_CHECK: code = PH_CHECK;
            ST_DONE:  code = PH_DONE;
            ST_FAIL:  code = PH_FAIL;
            default:  code = PH_IDLE;
        endcase
        return code;
    endfunction

endpackage

### hw/rtl/ufbs_front.sv
// ----------------------------------------------------------------------------
// ufbs_front
// Configuration registers and load sequencer; turns each item into one job.
// ----------------------------------------------------------------------------
module ufbs_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             accept,
    input  logic [1:0]       command,
    input  logic [7:0]       data,
    output ufbs_pkg::job_t   job
);
    import ufbs_pkg::*;

    logic [15:0] image_length_reg;
    logic [15:0] stx_timeout_reg;
    logic [15:0] reply_timeout_reg;

    state_t      state_reg, state_next;
    logic [7:0]  checksum_reg, checksum_next;
    logic [15:0] wait_reg, wait_next;
    logic [15:0] sent_reg, sent_next;
    logic [15:0] wait_inc;
    logic [15:0] sent_inc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_length_reg  <= IMAGE_LENGTH_RST;
            stx_timeout_reg   <= STX_TIMEOUT_RST;
            reply_timeout_reg <= REPLY_TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_LENGTH:  image_length_reg  <= cfg_data;
                REG_STX_TIMEOUT:   stx_timeout_reg   <= cfg_data;
                REG_REPLY_TIMEOUT: reply_timeout_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign wait_inc = (wait_reg == 16'hFFFF) ? wait_reg : wait_reg + 16'd1;
    assign sent_inc = sent_reg + 16'd1;

    always_comb
    begin
        state_next    = state_reg;
        checksum_next = checksum_reg;
        wait_next     = wait_reg;
        sent_next     = sent_reg;
        job           = '0;
        job.error     = ERR_NONE;
        case (command)
            CMD_START:
            begin
                state_next    = ST_STX;
                checksum_next = CHECK_INIT;
                wait_next     = '0;
                sent_next     = '0;
            end
            CMD_RX:
            begin
                case (state_reg)
                    ST_STX:
                    begin
                        if (data == BYTE_STX)
                        begin
                            state_next   = ST_ACK;
                            wait_next    = '0;
                            job.header   = 1'b1;
                            job.tx_valid = 1'b1;
                            job.tx_byte  = image_length_reg[7:0];
                            job.len_hi   = image_length_reg[15:8];
                        end
                    end
                    ST_ACK:
                    begin
                        if (data == BYTE_ACK)
                        begin
                            sent_next  = '0;
                            wait_next  = '0;
                            state_next = (image_length_reg == 16'd0) ? ST_CHECK : ST_IMAGE;
                        end
                        else
                        begin
                            state_next = ST_FAIL;
                            job.error  = ERR_UNEXPECTED;
                        end
                    end
                    ST_IMAGE:
                    begin
                        state_next = ST_FAIL;
                        job.error  = ERR_UNEXPECTED;
                    end
                    ST_CHECK:
                    begin
                        if (data == checksum_reg)
                        begin
                            state_next   = ST_DONE;
                            job.tx_valid = 1'b1;
                            job.tx_byte  = BYTE_ACK;
                        end
                        else
                        begin
                            state_next = ST_FAIL;
                            job.error  = ERR_MISMATCH;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_IMAGE:
            begin
                case (state_reg)
                    ST_IMAGE:
                    begin
                        checksum_next = checksum_reg ^ data;
                        sent_next     = sent_inc;
                        if (sent_inc == image_length_reg)
                        begin
                            state_next = ST_CHECK;
                            wait_next  = '0;
                        end
                        job.tx_valid = 1'b1;
                        job.tx_byte  = data;
                    end
                    ST_STX, ST_ACK, ST_CHECK:
                    begin
                        state_next = ST_FAIL;
                        job.error  = ERR_OUT_OF_PH;
                    end
                    default:
                        job.error = ERR_OUT_OF_PH;
                endcase
            end
            default:
            begin
                case (state_reg)
                    ST_STX:
                    begin
                        wait_next = wait_inc;
                        if (wait_inc >= stx_timeout_reg)
                        begin
                            state_next = ST_FAIL;
                            job.error  = ERR_STX_TIMEOUT;
                        end
                    end
                    ST_ACK:
                    begin
                        wait_next = wait_inc;
                        if (wait_inc >= reply_timeout_reg)
                        begin
                            state_next = ST_FAIL;
                            job.error  = ERR_ACK_TIMEOUT;
                        end
                    end
                    ST_CHECK:
                    begin
                        wait_next = wait_inc;
                        if (wait_inc >= reply_timeout_reg)
                        begin
                            state_next = ST_FAIL;
                            job.error  = ERR_CHK_TIMEOUT;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
        job.phase = phase_code(state_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            checksum_reg <= CHECK_INIT;
            wait_reg     <= '0;
            sent_reg     <= '0;
        end
        else if (accept)
        begin
            state_reg    <= state_next;
            checksum_reg <= checksum_next;
            wait_reg     <= wait_next;
            sent_reg     <= sent_next;
        end
    end

`ifndef ASSERT_OFF
    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        accept && command == CMD_START |=> state_reg == ST_STX)
        else $error("start did not arm the STX wait");
    a_tx_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        job.tx_valid |-> job.error == ERR_NONE)
        else $error("transmit job carries an error");
`endif

endmodule

### hw/rtl/ufbs_job_fifo.sv
// ----------------------------------------------------------------------------
// ufbs_job_fifo
// Short job queue between the sequencer and the result stage.
// ----------------------------------------------------------------------------
module ufbs_job_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  ufbs_pkg::job_t   wr_job,
    output logic             full,
    input  logic             rd_en,
    output ufbs_pkg::job_t   rd_job,
    output logic             empty
);
    import ufbs_pkg::*;

    job_t                mem [JOB_DEPTH];
    logic [JOB_AW-1:0]   wr_ptr_reg;
    logic [JOB_AW-1:0]   rd_ptr_reg;
    logic [JOB_AW:0]     count_reg;

    localparam logic [JOB_AW:0] DEPTH_CNT = (JOB_AW+1)'(JOB_DEPTH);
    localparam logic [JOB_AW-1:0] LAST_PTR = JOB_AW'(JOB_DEPTH - 1);
    localparam logic [JOB_AW-1:0] PTR_ONE = JOB_AW'(1);
    localparam logic [JOB_AW:0] CNT_ONE = (JOB_AW+1)'(1);

    assign full   = (count_reg == DEPTH_CNT);
    assign empty  = (count_reg == '0);
    assign rd_job = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_ONE;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_ONE;
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + CNT_ONE;
                2'b01:   count_reg <= count_reg - CNT_ONE;
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("job count beyond depth");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        full && !rd_en |=> full)
        else $error("job queue lost an entry");
`endif

endmodule

### hw/rtl/ufbs_back.sv
// ----------------------------------------------------------------------------
// ufbs_back
// Result stage: expands the head job into one or three result items.
// ----------------------------------------------------------------------------
module ufbs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  ufbs_pkg::job_t   head,
    input  logic             head_empty,
    output logic             head_pop,
    input  logic             pop,
    output logic             empty,
    output logic             tx_valid,
    output logic [7:0]       tx_byte,
    output logic [2:0]       phase,
    output logic [2:0]       error,
    output logic             last
);
    import ufbs_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       take;

    assign empty    = head_empty;
    assign take     = pop && !head_empty;
    assign last     = !head.header || (idx_reg == 2'd2);
    assign head_pop = take && last;
    assign tx_valid = head.tx_valid;
    assign phase    = head.phase;
    assign error    = head.error;

    always_comb
    begin
        case (idx_reg)
            2'd0:    tx_byte = head.header ? BYTE_SOH : head.tx_byte;
            2'd1:    tx_byte = head.tx_byte;
            default: tx_byte = head.len_hi;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

`ifndef ASSERT_OFF
    a_idx_header: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd0 |-> !head_empty && head.header)
        else $error("result index advanced outside a header job");
`endif

endmodule

### hw/rtl/uart_firmware_boot_sequencer.sv
// ----------------------------------------------------------------------------
// uart_firmware_boot_sequencer
// Host side of a UART firmware boot-load exchange.
// ----------------------------------------------------------------------------
// One item (start, received byte, image byte or tick) is accepted per cycle
// while full is low; the sequencer updates its state in that cycle and
// queues one job in a four-entry queue. Each job yields one result, except
// the STX reply, which yields three (SOH, length low, length high) over three
// pops. Sustained rate is one item per cycle for single-result items while
// pop stays high; the result stage, one result per pop, sets the rate for STX
// replies. Results appear on the ports once their job reaches the head of
// the queue. Configuration writes are always ready.
module uart_firmware_boot_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [7:0]  data,
    output logic        empty,
    input  logic        pop,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic [2:0]  phase,
    output logic [2:0]  error,
    output logic        last
);
    import ufbs_pkg::*;

    job_t job_in;
    job_t job_head;
    logic accept;
    logic q_empty;
    logic q_pop;

    assign accept = push && !full;

    ufbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .command   (command),
        .data      (data),
        .job       (job_in)
    );

    ufbs_job_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_job (job_in),
        .full   (full),
        .rd_en  (q_pop),
        .rd_job (job_head),
        .empty  (q_empty)
    );

    ufbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (job_head),
        .head_empty (q_empty),
        .head_pop   (q_pop),
        .pop        (pop),
        .empty      (empty),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte),
        .phase      (phase),
        .error      (error),
        .last       (last)
    );

endmodule

### tb/sv/uart_firmware_boot_sequencer_tb.sv
// ----------------------------------------------------------------------------
// uart_firmware_boot_sequencer_tb
// Self-checking bench for the UART boot-load sequencer. Directed loads and
// error paths come first, with one long receiver hold-off that fills the
// block, then random load sessions with random gaps on both queue sides.
// Every popped result is compared against an in-bench model of the sequence.
// ----------------------------------------------------------------------------
module uart_firmware_boot_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ufbs_pkg::*;

    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES = 60;
    localparam int         RANDOM_ITEMS = 85;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] phase;
        logic [2:0] error;
        logic       last;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  command = '0;
    logic [7:0]  data = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [2:0]  phase;
    logic [2:0]  error;
    logic        last;

    // sequence model
    logic [15:0] cfg_length;
    logic [15:0] cfg_stx_limit;
    logic [15:0] cfg_reply_limit;
    logic [2:0]  seq_phase;
    logic [7:0]  seq_checksum;
    logic [15:0] seq_ticks;
    logic [15:0] seq_sent;

    reply_t pending_replies[$];
    reply_t got_reply;
    reply_t want_reply;
    int     errors_seen = 0;
    int     items_sent = 0;
    int     next_gap = 0;
    int     pop_wait = 0;
    logic   push_armed = 1'b0;
    logic   no_idle = 1'b0;
    logic   hold_rx = 1'b0;
    event   hold_off_go;

    uart_firmware_boot_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .command   (command),
        .data      (data),
        .empty     (empty),
        .pop       (pop),
        .tx_valid  (tx_valid),
        .tx_byte   (tx_byte),
        .phase     (phase),
        .error     (error),
        .last      (last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

    function automatic void queue_reply(input logic txv, input logic [7:0] txb,
                                        input logic [2:0] err, input logic lst);
        reply_t r;
        r = '{txv, txb, seq_phase, err, lst};
        pending_replies.push_back(r);
    endfunction

    function automatic logic tick_expired(input logic [15:0] limit);
        if (seq_ticks != 16'hFFFF)
            seq_ticks = seq_ticks + 16'd1;
        return seq_ticks >= limit;
    endfunction

    task automatic reset_model();
        cfg_length      = IMAGE_LENGTH_RST;
        cfg_stx_limit   = STX_TIMEOUT_RST;
        cfg_reply_limit = REPLY_TIMEOUT_RST;
        seq_phase       = PH_IDLE;
        seq_checksum    = CHECK_INIT;
        seq_ticks       = '0;
        seq_sent        = '0;
    endtask

    task automatic predict_replies(input logic [1:0] cmd, input logic [7:0] d);
        logic [2:0] err;
        logic [2:0] ph;
        err = ERR_NONE;
        ph  = seq_phase;
        case (cmd)
            CMD_START:
            begin
                seq_phase    = PH_STX;
                seq_checksum = CHECK_INIT;
                seq_ticks    = '0;
                seq_sent     = '0;
            end
            CMD_RX:
            begin
                if (ph == PH_STX && d == BYTE_STX)
                begin
                    seq_phase = PH_ACK;
                    seq_ticks = '0;
                    queue_reply(1'b1, BYTE_SOH, ERR_NONE, 1'b0);
                    queue_reply(1'b1, cfg_length[7:0], ERR_NONE, 1'b0);
                    queue_reply(1'b1, cfg_length[15:8], ERR_NONE, 1'b1);
                    return;
                end
                if (ph == PH_ACK)
                begin
                    if (d == BYTE_ACK)
                    begin
                        seq_sent  = '0;
                        seq_ticks = '0;
                        seq_phase = (cfg_length == 16'd0) ? PH_CHECK : PH_IMAGE;
                    end
                    else
                    begin
                        seq_phase = PH_FAIL;
                        err       = ERR_UNEXPECTED;
                    end
                end
                else if (ph == PH_IMAGE)
                begin
                    seq_phase = PH_FAIL;
                    err       = ERR_UNEXPECTED;
                end
                else if (ph == PH_CHECK)
                begin
                    if (d == seq_checksum)
                    begin
                        seq_phase = PH_DONE;
                        queue_reply(1'b1, BYTE_ACK, ERR_NONE, 1'b1);
                        return;
                    end
                    seq_phase = PH_FAIL;
                    err       = ERR_MISMATCH;
                end
            end
            CMD_IMAGE:
            begin
                if (ph == PH_IMAGE)
                begin
                    seq_checksum = seq_checksum ^ d;
                    seq_sent     = seq_sent + 16'd1;
                    if (seq_sent == cfg_length)
                    begin
                        seq_phase = PH_CHECK;
                        seq_ticks = '0;
                    end
                    queue_reply(1'b1, d, ERR_NONE, 1'b1);
                    return;
                end
                err = ERR_OUT_OF_PH;
                if (ph == PH_STX || ph == PH_ACK || ph == PH_CHECK)
                    seq_phase = PH_FAIL;
            end
            default:
            begin
                if (ph == PH_STX)
                begin
                    if (tick_expired(cfg_stx_limit))
                    begin
                        seq_phase = PH_FAIL;
                        err       = ERR_STX_TIMEOUT;
                    end
                end
                else if (ph == PH_ACK)
                begin
                    if (tick_expired(cfg_reply_limit))
                    begin
                        seq_phase = PH_FAIL;
                        err       = ERR_ACK_TIMEOUT;
                    end
                end
                else if (ph == PH_CHECK)
                begin
                    if (tick_expired(cfg_reply_limit))
                    begin
                        seq_phase = PH_FAIL;
                        err       = ERR_CHK_TIMEOUT;
                    end
                end
            end
        endcase
        queue_reply(1'b0, 8'h00, err, 1'b1);
    endtask

    // result checker and pop driver
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            got_reply = '{tx_valid, tx_byte, phase, error, last};
            if (pending_replies.size() == 0)
            begin
                errors_seen++;
                if (errors_seen <= 10)
                    $display("unexpected item: txv=%0d byte=%02h phase=%0d err=%0d last=%0d",
                             tx_valid, tx_byte, phase, error, last);
            end
            else
            begin
                want_reply = pending_replies.pop_front();
                if (got_reply !== want_reply)
                begin
                    errors_seen++;
                    if (errors_seen <= 10)
                        $display("mismatch: exp txv=%0d byte=%02h phase=%0d err=%0d last=%0d",
                                 want_reply.tx_valid, want_reply.tx_byte, want_reply.phase,
                                 want_reply.error, want_reply.last,
                                 ", got txv=%0d byte=%02h phase=%0d err=%0d last=%0d",
                                 tx_valid, tx_byte, phase, error, last);
                end
            end
            pop_wait = no_idle ? 0 : $urandom_range(0, 7);
        end
        else if (pop_wait > 0)
        begin
            pop_wait--;
        end
        pop <= rst_n && !hold_rx && (pop_wait == 0);
    end

    // long receiver hold-off
    initial
    begin
        forever
        begin
            @(hold_off_go);
            hold_rx <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_rx <= 1'b0;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] d);
        if (next_gap > 0)
            repeat (next_gap) @(posedge clk);
        push    <= 1'b1;
        command <= cmd;
        data    <= d;
        do
            @(posedge clk);
        while (full);
        predict_replies(cmd, d);
        items_sent++;
        next_gap = no_idle ? 0 : $urandom_range(0, 7);
        if (next_gap > 0)
        begin
            push <= 1'b0;
            push_armed = 1'b0;
        end
        else
        begin
            push_armed = 1'b1;
        end
    endtask

    task automatic stop_push();
        if (push_armed)
        begin
            push <= 1'b0;
            push_armed = 1'b0;
        end
    endtask

    task automatic wait_idle();
        stop_push();
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_IMAGE_LENGTH:  cfg_length      = val;
            REG_STX_TIMEOUT:   cfg_stx_limit   = val;
            REG_REPLY_TIMEOUT: cfg_reply_limit = val;
            default: ;
        endcase
    endtask

    // idle phase ignores rx and ticks, flags an image byte
    task automatic test_idle_items();
        send_item(CMD_TICK, 8'hFF);
        send_item(CMD_IMAGE, 8'h00);
        send_item(CMD_RX, 8'hFF);
    endtask

    task automatic test_default_load();
        send_item(CMD_START, 8'h00);
        send_item(CMD_RX, 8'h00);
        send_item(CMD_RX, BYTE_STX);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_RX, BYTE_ACK);
        send_item(CMD_IMAGE, 8'hFF);
        send_item(CMD_RX, 8'hFF);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_RX, 8'h12);
        send_item(CMD_IMAGE, 8'h5A);
    endtask

    task automatic test_length_extremes();
        write_reg(REG_IMAGE_LENGTH, 16'h0000);
        send_item(CMD_START, 8'h00);
        send_item(CMD_RX, BYTE_STX);
        send_item(CMD_RX, BYTE_ACK);
        send_item(CMD_RX, 8'h00);
        write_reg(REG_IMAGE_LENGTH, 16'hFFFF);
        send_item(CMD_START, 8'h00);
        send_item(CMD_RX, BYTE_STX);
        send_item(CMD_RX, BYTE_ACK);
        send_item(CMD_IMAGE, 8'hA5);
        send_item(CMD_START, 8'h00);
        send_item(CMD_IMAGE, 8'h3C);
        send_item(CMD_IMAGE, 8'hC3);
    endtask

    task automatic test_timeouts();
        write_reg(REG_STX_TIMEOUT, 16'h0000);
        write_reg(REG_REPLY_TIMEOUT, 16'hFFFF);
        write_reg(REG_UNUSED, 16'h0001);
        send_item(CMD_START, 8'h00);
        send_item(CMD_TICK, 8'h00);
        write_reg(REG_STX_TIMEOUT, 16'hFFFF);
        write_reg(REG_REPLY_TIMEOUT, 16'h0000);
        send_item(CMD_START, 8'h00);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_RX, BYTE_STX);
        send_item(CMD_TICK, 8'h00);
        write_reg(REG_IMAGE_LENGTH, 16'h0001);
        write_reg(REG_STX_TIMEOUT, 16'h0002);
        write_reg(REG_REPLY_TIMEOUT, 16'h0001);
        send_item(CMD_START, 8'h00);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_START, 8'h00);
        send_item(CMD_RX, BYTE_STX);
        send_item(CMD_RX, BYTE_ACK);
        send_item(CMD_IMAGE, 8'h81);
        send_item(CMD_TICK, 8'h00);
    endtask

    task automatic test_protocol_errors();
        write_reg(REG_REPLY_TIMEOUT, 16'd20);
        send_item(CMD_START, 8'h00);
        send_item(CMD_RX, BYTE_STX);
        send_item(CMD_RX, 8'h15);
        send_item(CMD_IMAGE, 8'h77);
        send_item(CMD_START, 8'h00);
        send_item(CMD_RX, BYTE_STX);
        send_item(CMD_IMAGE, 8'h66);
        send_item(CMD_START, 8'h00);
        send_item(CMD_RX, BYTE_STX);
        send_item(CMD_RX, BYTE_ACK);
        send_item(CMD_IMAGE, 8'h0F);
        send_item(CMD_RX, 8'h0F);
    endtask

    // one load with random content; mostly well formed, sometimes broken
    task automatic run_load_session();
        logic [7:0] flip;
        int n;
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(REG_IMAGE_LENGTH, 16'(($urandom_range(0, 9) == 0) ?
                      $urandom_range(7, 30) : $urandom_range(0, 6)));
            write_reg(REG_STX_TIMEOUT, 16'($urandom_range(1, 8)));
            write_reg(REG_REPLY_TIMEOUT, 16'($urandom_range(1, 8)));
        end
        send_item(CMD_START, 8'($urandom_range(0, 255)));
        n = $urandom_range(0, 3);
        repeat (n)
        begin
            if ($urandom_range(0, 1) == 0)
                send_item(CMD_TICK, 8'($urandom_range(0, 255)));
            else
                send_item(CMD_RX, 8'($urandom_range(0, 255)));
        end
        if (seq_phase == PH_STX)
            send_item(CMD_RX, BYTE_STX);
        n = $urandom_range(0, 2);
        repeat (n)
        begin
            if (seq_phase == PH_ACK)
                send_item(CMD_TICK, 8'($urandom_range(0, 255)));
        end
        if (seq_phase == PH_ACK)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(CMD_RX, 8'($urandom_range(0, 255)));
            else
                send_item(CMD_RX, BYTE_ACK);
        end
        while (seq_phase == PH_IMAGE)
        begin
            n = $urandom_range(0, 19);
            if (n == 0)
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else if (n < 3)
                send_item(CMD_TICK, 8'($urandom_range(0, 255)));
            else
                send_item(CMD_IMAGE, 8'($urandom_range(0, 255)));
        end
        n = $urandom_range(0, 2);
        repeat (n)
        begin
            if (seq_phase == PH_CHECK)
                send_item(CMD_TICK, 8'($urandom_range(0, 255)));
        end
        if (seq_phase == PH_CHECK)
        begin
            flip = 8'($urandom_range(1, 255));
            if ($urandom_range(0, 4) == 0)
                send_item(CMD_RX, seq_checksum ^ flip);
            else
                send_item(CMD_RX, seq_checksum);
        end
        if ($urandom_range(0, 2) == 0)
            send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_loads();
        int goal;
        int session;
        goal = items_sent + RANDOM_ITEMS;
        session = 0;
        while (items_sent < goal)
        begin
            no_idle = (session % 4 == 3);
            run_load_session();
            session++;
        end
        no_idle = 1'b0;
    endtask

    // receiver stalls while the sender keeps pushing
    task automatic test_backpressure();
        write_reg(REG_IMAGE_LENGTH, 16'd6);
        write_reg(REG_STX_TIMEOUT, 16'd50);
        write_reg(REG_REPLY_TIMEOUT, 16'd50);
        no_idle = 1'b1;
        -> hold_off_go;
        send_item(CMD_START, 8'h00);
        send_item(CMD_RX, BYTE_STX);
        send_item(CMD_RX, BYTE_ACK);
        repeat (6)
            send_item(CMD_IMAGE, 8'($urandom_range(0, 255)));
        send_item(CMD_RX, seq_checksum);
        send_item(CMD_START, 8'h00);
        send_item(CMD_RX, BYTE_STX);
        send_item(CMD_RX, BYTE_STX);
        send_item(CMD_TICK, 8'h00);
        no_idle = 1'b0;
    endtask

    task automatic finish_run();
        int guard;
        stop_push();
        guard = 0;
        while (pending_replies.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            errors_seen++;
            $display("%0d expected items never arrived", pending_replies.size());
        end
        if (errors_seen == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    endtask

    initial
    begin
        reset_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_items();
        test_default_load();
        test_length_extremes();
        test_timeouts();
        test_protocol_errors();
        test_backpressure();
        test_random_loads();
        finish_run();
    end

endmodule
